/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the Rice decoder, included by rcd_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RCD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle.
`define RCD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/rcd_pkg.sv */
// Types and constants of the Rice code stream decoder.
package rcd_pkg;

    localparam int WORD_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int K_W         = 6;
    localparam int BITS_W      = 6;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // Largest suffix width, width-code suffix size, width quotient saturation
    localparam logic [K_W-1:0]     MAX_WIDTH       = 6'd32;
    localparam logic [K_W-1:0]     WIDTH_CODE_BITS = 6'd2;
    localparam logic [VALUE_W-1:0] WIDTH_QUOT_SAT  = 32'd9;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_BITS    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PREFIXED = 4'd1;

    typedef struct packed {
        logic [K_W-1:0] suffix_bits;
        logic           width_prefixed;
    } rcd_cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               width_clamped;
        logic               last;
    } rcd_result_t;

endpackage

/* rtl/rcd_ifs.sv */
// Handshake channel interfaces: stream words, decoded results, register writes.
interface rcd_word_if import rcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface rcd_result_if import rcd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               width_clamped;
    logic               last;

    modport source (output valid, output value, output width_clamped, output last,
                    input ready);
    modport sink   (input valid, input value, input width_clamped, input last,
                    output ready);
endinterface

interface rcd_cfg_if import rcd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rice_code_stream_decoder_unit.sv */
// Rice code stream decoder: word queue, bit-serial decoder and configuration registers.
//
// Usage:
//   words   : 32-bit stream words, first stream bit in bit 31; a beat moves at
//             valid && ready. A short queue takes beats while the decoder works.
//   results : one beat per decoded value (value, width_clamped, last); last
//             marks the final value completed by a word.
//   cfg     : register writes, index 0 suffix_bits, index 1 width_prefixed;
//             always ready, write only while the block is idle.
// Throughput: the decoder loads a word and then reads one stream bit per cycle
//   while results is not stalled; it takes the next word only after the last
//   bit, and after a flush of the held value when the word's final bit completes
//   a value while an earlier value of that word is still held.
// Output: a value is shown once the next value of its word completes or the
//   word ends.
// Reset: queue empty, decoder at the start of a code, registers zero.
// Stall: when results is not taken the decoder holds its bit position and the
//   queue keeps accepting words until it is full.
module rice_code_stream_decoder_unit import rcd_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    rcd_word_if.sink      words,
    rcd_result_if.source  results,
    rcd_cfg_if.sink       cfg
);

    rcd_cfg_t cfg_regs_reg, cfg_regs_next;

    rcd_word_if q_ch ();

    assign cfg.ready = 1'b1;

    // Configuration register writes
    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SUFFIX_BITS:    cfg_regs_next.suffix_bits    = cfg.data[K_W-1:0];
                REG_WIDTH_PREFIXED: cfg_regs_next.width_prefixed = cfg.data[0];
                default:            cfg_regs_next = cfg_regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg <= '0;
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    rcd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .words (words),
        .q     (q_ch.source)
    );

    rcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs_reg),
        .q        (q_ch.sink),
        .results  (results)
    );

endmodule

/* rtl/rcd_front.sv */
// Front end: accepts stream words into a short queue ahead of the decoder.
module rcd_front import rcd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    rcd_word_if.sink   words,
    rcd_word_if.source q
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] queue_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign words.ready = (count_reg != CNT_W'(DEPTH));
    assign q.valid     = (count_reg != '0);
    assign q.word      = queue_mem[rd_ptr_reg];

    assign push = words.valid && words.ready;
    assign pop  = q.valid && q.ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= words.word;
        end
    end

endmodule

/* rtl/rcd_back.sv */
// Back end: bit-serial Rice decoder with a held result and an output register.
`include "assert_macros.svh"

module rcd_back import rcd_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  rcd_cfg_t      cfg_regs,
    rcd_word_if.sink      q,
    rcd_result_if.source  results
);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_WIDTH_SUF,
        PH_VALUE_ZEROS,
        PH_VALUE_SUF
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [BITS_W-1:0]  bits_left_reg, bits_left_next;
    logic [VALUE_W-1:0] partial_reg, partial_next;
    logic [K_W-1:0]     suffix_left_reg, suffix_left_next;
    logic [K_W-1:0]     cur_width_reg, cur_width_next;
    logic               clamp_reg, clamp_next;
    logic               held_valid_reg, held_valid_next;
    rcd_result_t        held_reg, held_next;
    logic               flush_reg, flush_next;
    logic               out_valid_reg, out_valid_next;
    rcd_result_t        out_reg, out_next;

    logic               slot_free;
    logic               step;
    logic               bit_in;
    logic               last_bit;
    logic               done;
    logic [VALUE_W-1:0] shifted;
    logic [K_W-1:0]     plain_k;
    rcd_result_t        new_res;

    assign slot_free = !out_valid_reg || results.ready;
    assign step      = (bits_left_reg != '0) && slot_free;
    assign q.ready   = (bits_left_reg == '0) && !flush_reg;
    assign bit_in    = word_reg[WORD_W-1];
    assign last_bit  = (bits_left_reg == BITS_W'(1));
    assign shifted   = {partial_reg[VALUE_W-2:0], bit_in};
    assign plain_k   = (cfg_regs.suffix_bits > MAX_WIDTH) ? MAX_WIDTH : cfg_regs.suffix_bits;

    assign results.valid         = out_valid_reg;
    assign results.value         = out_reg.value;
    assign results.width_clamped = out_reg.width_clamped;
    assign results.last          = out_reg.last;

    // Decode of one stream bit
    always_comb
    begin
        phase_next       = phase_reg;
        partial_next     = partial_reg;
        suffix_left_next = suffix_left_reg;
        cur_width_next   = cur_width_reg;
        clamp_next       = clamp_reg;
        done             = 1'b0;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (cfg_regs.width_prefixed)
                begin
                    if (!bit_in)
                    begin
                        if (partial_reg < WIDTH_QUOT_SAT)
                        begin
                            partial_next = partial_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        suffix_left_next = WIDTH_CODE_BITS;
                        phase_next       = PH_WIDTH_SUF;
                    end
                end
                else if (!bit_in)
                begin
                    partial_next = partial_reg + 1'b1;
                end
                else
                begin
                    clamp_next = 1'b0;
                    if (plain_k == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        suffix_left_next = plain_k;
                        phase_next       = PH_VALUE_SUF;
                    end
                end
            end
            PH_WIDTH_SUF:
            begin
                partial_next     = shifted;
                suffix_left_next = suffix_left_reg - 1'b1;
                if (suffix_left_next == '0)
                begin
                    if (shifted > VALUE_W'(MAX_WIDTH))
                    begin
                        cur_width_next = MAX_WIDTH;
                        clamp_next     = 1'b1;
                    end
                    else
                    begin
                        cur_width_next = shifted[K_W-1:0];
                        clamp_next     = 1'b0;
                    end
                    partial_next = '0;
                    phase_next   = PH_VALUE_ZEROS;
                end
            end
            PH_VALUE_ZEROS:
            begin
                if (!bit_in)
                begin
                    partial_next = partial_reg + 1'b1;
                end
                else if (cur_width_reg == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    suffix_left_next = cur_width_reg;
                    phase_next       = PH_VALUE_SUF;
                end
            end
            PH_VALUE_SUF:
            begin
                partial_next = shifted;
                if (suffix_left_reg != '0)
                begin
                    suffix_left_next = suffix_left_reg - 1'b1;
                end
                if (suffix_left_next == '0)
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_LEAD;
            end
        endcase

        new_res.value         = partial_next;
        new_res.width_clamped = clamp_next;
        new_res.last          = 1'b0;

        if (done)
        begin
            partial_next     = '0;
            clamp_next       = 1'b0;
            suffix_left_next = '0;
            phase_next       = PH_LEAD;
        end
    end

    // Word loading, result holding and output register
    always_comb
    begin
        word_next       = word_reg;
        bits_left_next  = bits_left_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        flush_next      = flush_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q.valid && q.ready)
        begin
            word_next      = q.word;
            bits_left_next = BITS_W'(WORD_W);
        end
        else if (flush_reg && slot_free)
        begin
            // Word ended on a value while an earlier one was held
            out_valid_next  = 1'b1;
            out_next        = held_reg;
            out_next.last   = 1'b1;
            held_valid_next = 1'b0;
            flush_next      = 1'b0;
        end
        else if (step)
        begin
            word_next      = {word_reg[WORD_W-2:0], 1'b0};
            bits_left_next = bits_left_reg - 1'b1;
            if (done && held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = held_reg;
                out_next.last  = 1'b0;
                held_next      = new_res;
                flush_next     = last_bit;
            end
            else if (done)
            begin
                if (last_bit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = new_res;
                    out_next.last  = 1'b1;
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_next       = new_res;
                end
            end
            else if (last_bit && held_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = held_reg;
                out_next.last   = 1'b1;
                held_valid_next = 1'b0;
            end
        end
    end

    // Decoder state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            word_reg        <= '0;
            bits_left_reg   <= '0;
            partial_reg     <= '0;
            suffix_left_reg <= '0;
            cur_width_reg   <= '0;
            clamp_reg       <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_reg        <= '0;
            flush_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            word_reg       <= word_next;
            bits_left_reg  <= bits_left_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            if (step && !flush_reg)
            begin
                phase_reg       <= phase_next;
                partial_reg     <= partial_next;
                suffix_left_reg <= suffix_left_next;
                cur_width_reg   <= cur_width_next;
                clamp_reg       <= clamp_next;
            end
        end
    end

    // Checks
    `RCD_ASSERT_IMPL(a_flush_holds, clk, rst_n, flush_reg, held_valid_reg && (bits_left_reg == '0))
    `RCD_ASSERT_IMPL(a_no_held_between_words, clk, rst_n, (bits_left_reg == '0) && !flush_reg, !held_valid_reg)
    `RCD_ASSERT_IMPL(a_width_suffix_count, clk, rst_n, phase_reg == PH_WIDTH_SUF, (suffix_left_reg != '0) && (suffix_left_reg <= WIDTH_CODE_BITS))
    `RCD_ASSERT_NEXT(a_flush_emits_last, clk, rst_n, flush_reg && slot_free, out_valid_reg && out_reg.last && !flush_reg)

endmodule
